// ===== rtl/slc_pkg.sv =====
// Shared types, constants and pixel helpers for the sprite line compositor.
// No dependencies; every other file imports this package.
package slc_pkg;

    // Default sizes, used as the defaults of the top level parameters
    localparam int DEF_SPRITE_COUNT  = 64;
    localparam int DEF_PATTERN_COUNT = 512;
    localparam int DEF_MAX_PER_LINE  = 8;

    localparam int LINE_WIDTH  = 256;
    localparam int QUEUE_DEPTH = 2;

    // Sprite list terminator and y wrap point
    localparam logic [7:0]        END_MARK = 8'd208;
    localparam logic signed [9:0] Y_WRAP   = 10'sd240;

    // Pixel bits
    localparam logic [6:0] PIX_MARK = 7'h40;
    localparam logic [6:0] PIX_PRIO = 7'h20;
    localparam logic [6:0] SPR_FILL = 7'h50;

    // Input mode codes
    localparam logic [2:0] MODE_SPRITE  = 3'd0;
    localparam logic [2:0] MODE_PATTERN = 3'd1;
    localparam logic [2:0] MODE_PIXEL   = 3'd2;
    localparam logic [2:0] MODE_RENDER  = 3'd3;
    localparam logic [2:0] MODE_READ    = 3'd4;

    // Configuration register indexes
    localparam logic [2:0] CFG_TALL = 3'd0;
    localparam logic [2:0] CFG_ZOOM = 3'd1;
    localparam logic [2:0] CFG_SHIFT = 3'd2;
    localparam logic [2:0] CFG_HIGH = 3'd3;
    localparam logic [2:0] CFG_EXT  = 3'd4;

    typedef enum logic [2:0] {
        OP_SPRITE,
        OP_PATTERN,
        OP_PIXEL,
        OP_RENDER,
        OP_READ,
        OP_NONE
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [5:0]  spr_idx;
        logic [7:0]  spr_y;
        logic [7:0]  spr_x;
        logic [7:0]  spr_name;
        logic [11:0] pat_addr;
        logic [31:0] pat_word;
        logic [7:0]  pix_x;
        logic [6:0]  pix_val;
        logic [7:0]  line;
    } cmd_t;

    typedef struct packed {
        logic tall;
        logic zoom;
        logic shift;
        logic high;
        logic ext;
    } cfg_t;

    // Four bitplane bytes to eight packed nibbles, leftmost pixel in the low nibble
    function automatic logic [31:0] pack_planes(input logic [31:0] planes);
        logic [31:0] word;
        word = '0;
        for (int x = 0; x < 8; x++) begin
            for (int k = 0; k < 4; k++) begin
                word[4*x + k] = planes[8*k + 7 - x];
            end
        end
        return word;
    endfunction

    // Opaque sprite colour over a line buffer pixel
    function automatic logic [6:0] merge_pixel(input logic [6:0] b, input logic [3:0] s);
        logic [6:0] r;
        if ((b & PIX_MARK) != '0) begin
            r = b;
        end
        else if (((b & PIX_PRIO) != '0) && (b[3:0] != 4'd0)) begin
            r = b | PIX_MARK;
        end
        else begin
            r = {3'b000, s} | SPR_FILL;
        end
        return r;
    endfunction

endpackage

// ===== rtl/slc_front.sv =====
// Front end: decodes an incoming transaction into a queued command.
// Depends on slc_pkg.
module slc_front import slc_pkg::*; #(
    parameter int SPRITE_COUNT  = DEF_SPRITE_COUNT,
    parameter int PATTERN_COUNT = DEF_PATTERN_COUNT
) (
    input  logic [2:0]  mode,
    input  logic [5:0]  sprite_index,
    input  logic [7:0]  sprite_y,
    input  logic [7:0]  sprite_x,
    input  logic [7:0]  sprite_name,
    input  logic [8:0]  pattern_index,
    input  logic [2:0]  pattern_row,
    input  logic [31:0] pattern_planes,
    input  logic [7:0]  pixel_x,
    input  logic [6:0]  pixel_value,
    input  logic [7:0]  line,
    output cmd_t        cmd
);

    // Classify; out-of-range table writes become no-ops
    always_comb
    begin
        cmd.spr_idx  = sprite_index;
        cmd.spr_y    = sprite_y;
        cmd.spr_x    = sprite_x;
        cmd.spr_name = sprite_name;
        cmd.pat_addr = {pattern_index, pattern_row};
        cmd.pat_word = pack_planes(pattern_planes);
        cmd.pix_x    = pixel_x;
        cmd.pix_val  = pixel_value;
        cmd.line     = line;
        case (mode)
            MODE_SPRITE:
                cmd.op = (7'(sprite_index) < 7'(SPRITE_COUNT)) ? OP_SPRITE : OP_NONE;
            MODE_PATTERN:
                cmd.op = (10'(pattern_index) < 10'(PATTERN_COUNT)) ? OP_PATTERN : OP_NONE;
            MODE_PIXEL:  cmd.op = OP_PIXEL;
            MODE_RENDER: cmd.op = OP_RENDER;
            MODE_READ:   cmd.op = OP_READ;
            default:     cmd.op = OP_NONE;
        endcase
    end

endmodule

// ===== rtl/slc_queue.sv =====
// Short command queue between front end and render engine.
// Depends on slc_pkg.
module slc_queue import slc_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output logic full,
    output logic valid,
    output cmd_t head
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    cmd_t          entry_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full  = (count_reg == CW'(QUEUE_DEPTH));
    assign valid = (count_reg != '0);
    assign head  = entry_reg[rd_ptr_reg];

    // Pointer and fill update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Payload storage
    always_ff @(posedge clk)
    begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== rtl/slc_engine.sv =====
// Back end: sprite table, pattern store and line buffer with the render sequencer.
// Depends on slc_pkg.
module slc_engine import slc_pkg::*; #(
    parameter int SPRITE_COUNT  = DEF_SPRITE_COUNT,
    parameter int PATTERN_COUNT = DEF_PATTERN_COUNT,
    parameter int MAX_PER_LINE  = DEF_MAX_PER_LINE
) (
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       q_valid,
    input  cmd_t       q_cmd,
    output logic       q_pop,
    output logic       clearing,
    output logic       done,
    output logic [6:0] pixel_out,
    output logic       overflow,
    output logic       collision
);

    localparam int SIW    = $clog2(SPRITE_COUNT);
    localparam int PIW    = $clog2(PATTERN_COUNT);
    localparam int PAW    = PIW + 3;
    localparam int PDEPTH = PATTERN_COUNT * 8;
    localparam int CNW    = $clog2(MAX_PER_LINE + 1);
    localparam logic [9:0] PC10 = 10'(PATTERN_COUNT);

    typedef enum logic [9:0] {
        ST_CLEAR  = 10'b0000000001,
        ST_IDLE   = 10'b0000000010,
        ST_FETCH  = 10'b0000000100,
        ST_EVAL   = 10'b0000001000,
        ST_NAME   = 10'b0000010000,
        ST_PAT    = 10'b0000100000,
        ST_DRAW   = 10'b0001000000,
        ST_DRAIN  = 10'b0010000000,
        ST_READ   = 10'b0100000000,
        ST_FINISH = 10'b1000000000
    } state_t;

    // Memories
    logic [23:0] spr_mem  [SPRITE_COUNT];
    logic [31:0] pat_mem  [PDEPTH];
    logic [6:0]  line_mem [LINE_WIDTH];
    logic [23:0] spr_rdata_reg;
    logic [31:0] pat_rdata_reg;
    logic [6:0]  line_rdata_reg;

    state_t             state_reg, state_next;
    logic [PAW-1:0]     clr_cnt_reg, clr_cnt_next;
    logic [SIW-1:0]     idx_reg, idx_next;
    logic [CNW-1:0]     count_reg, count_next;
    logic [7:0]         line_reg, line_next;
    logic signed [9:0]  xp_reg, xp_next;
    logic [9:0]         n_reg, n_next;
    logic [3:0]         row_reg, row_next;
    logic [3:0]         x_cnt_reg, x_cnt_next;
    logic               ovf_reg, ovf_next;
    logic               coll_reg, coll_next;
    logic               pend_reg, pend_next;
    logic [7:0]         pend_pos_reg, pend_pos_next;
    logic [3:0]         pend_sp_reg, pend_sp_next;
    logic               done_reg, done_next;
    logic [6:0]         pix_reg, pix_next;
    logic               ovf_out_reg, ovf_out_next;
    logic               col_out_reg, col_out_next;

    // Memory port controls
    logic           spr_we, spr_re;
    logic           pat_we, pat_re;
    logic [PAW-1:0] pat_waddr, pat_raddr;
    logic [31:0]    pat_wdata;
    logic           line_we, line_re;
    logic [7:0]     line_waddr, line_raddr;
    logic [6:0]     line_wdata;

    // Sprite evaluation terms
    logic [7:0]        ev_y, ev_x, ev_name;
    logic signed [9:0] ev_top, ev_line, ev_height;
    logic [9:0]        ev_row;
    logic              ev_hit, ev_stop, last_sprite;
    logic [9:0]        n_mod;
    logic [2:0]        px;
    logic [3:0]        sp;
    logic signed [9:0] pos;
    logic              draw_hit, last_x;

    assign q_pop     = (state_reg == ST_IDLE) && q_valid;
    assign clearing  = (state_reg == ST_CLEAR);
    assign done      = done_reg;
    assign pixel_out = pix_reg;
    assign overflow  = ovf_out_reg;
    assign collision = col_out_reg;

    // Sprite entry geometry
    always_comb
    begin
        ev_y      = spr_rdata_reg[23:16];
        ev_x      = spr_rdata_reg[15:8];
        ev_name   = spr_rdata_reg[7:0];
        ev_top    = $signed({2'b00, ev_y}) + 10'sd1;
        if (ev_top > Y_WRAP) begin
            ev_top = ev_top - 10'sd256;
        end
        ev_line   = $signed({2'b00, line_reg});
        ev_height = (cfg.tall ? 10'sd16 : 10'sd8) <<< cfg.zoom;
        ev_hit    = (ev_line >= ev_top) && (ev_line < ev_top + ev_height);
        ev_row    = 10'(ev_line - ev_top);
        ev_stop   = !cfg.ext && (ev_y == END_MARK);
        last_sprite = (idx_reg == SIW'(SPRITE_COUNT - 1));
        n_mod     = (n_reg >= PC10) ? n_reg - PC10 : n_reg;
    end

    // Pixel selection for the draw loop
    always_comb
    begin
        px       = cfg.zoom ? x_cnt_reg[3:1] : x_cnt_reg[2:0];
        sp       = pat_rdata_reg[4*px +: 4];
        pos      = xp_reg + $signed({6'b000000, x_cnt_reg});
        draw_hit = (state_reg == ST_DRAW) && (sp != 4'd0) && (pos[9:8] == 2'b00);
        last_x   = (x_cnt_reg == (cfg.zoom ? 4'd15 : 4'd7));
    end

    // Memory port steering
    always_comb
    begin
        spr_we     = (state_reg == ST_IDLE) && q_valid && (q_cmd.op == OP_SPRITE);
        spr_re     = (state_reg == ST_FETCH);
        pat_we     = 1'b0;
        pat_waddr  = q_cmd.pat_addr[PAW-1:0];
        pat_wdata  = q_cmd.pat_word;
        pat_re     = (state_reg == ST_PAT);
        pat_raddr  = {n_mod[PIW-1:0], row_reg[2:0]};
        line_we    = 1'b0;
        line_waddr = q_cmd.pix_x;
        line_wdata = q_cmd.pix_val;
        line_re    = 1'b0;
        line_raddr = q_cmd.pix_x;
        if (state_reg == ST_CLEAR) begin
            pat_we     = 1'b1;
            pat_waddr  = clr_cnt_reg;
            pat_wdata  = '0;
            line_we    = 1'b1;
            line_waddr = clr_cnt_reg[7:0];
            line_wdata = '0;
        end
        else if (pend_reg) begin
            line_we    = 1'b1;
            line_waddr = pend_pos_reg;
            line_wdata = merge_pixel(line_rdata_reg, pend_sp_reg);
        end
        else if ((state_reg == ST_IDLE) && q_valid) begin
            pat_we  = (q_cmd.op == OP_PATTERN);
            line_we = (q_cmd.op == OP_PIXEL);
            line_re = (q_cmd.op == OP_READ);
        end
        if (draw_hit) begin
            line_re    = 1'b1;
            line_raddr = pos[7:0];
        end
    end

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        idx_next      = idx_reg;
        count_next    = count_reg;
        line_next     = line_reg;
        xp_next       = xp_reg;
        n_next        = n_reg;
        row_next      = row_reg;
        x_cnt_next    = x_cnt_reg;
        ovf_next      = ovf_reg;
        coll_next     = coll_reg | (pend_reg & line_rdata_reg[6]);
        pend_next     = draw_hit;
        pend_pos_next = pos[7:0];
        pend_sp_next  = sp;
        done_next     = 1'b0;
        pix_next      = '0;
        ovf_out_next  = 1'b0;
        col_out_next  = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == PAW'(PDEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (q_valid) begin
                    case (q_cmd.op)
                        OP_RENDER:
                        begin
                            line_next  = q_cmd.line;
                            idx_next   = '0;
                            count_next = '0;
                            ovf_next   = 1'b0;
                            coll_next  = 1'b0;
                            state_next = ST_FETCH;
                        end
                        OP_READ:  state_next = ST_READ;
                        default:  done_next  = 1'b1;
                    endcase
                end
            end
            ST_FETCH:
            begin
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (ev_stop) begin
                    state_next = ST_FINISH;
                end
                else if (ev_hit) begin
                    if (count_reg == CNW'(MAX_PER_LINE)) begin
                        ovf_next   = 1'b1;
                        state_next = ST_FINISH;
                    end
                    else begin
                        count_next = count_reg + 1'b1;
                        xp_next    = $signed({2'b00, ev_x}) - (cfg.shift ? 10'sd8 : 10'sd0);
                        n_next     = {1'b0, cfg.high, ev_name[7:1], ev_name[0] & !cfg.tall};
                        row_next   = cfg.zoom ? ev_row[4:1] : ev_row[3:0];
                        state_next = ST_NAME;
                    end
                end
                else if (last_sprite) begin
                    state_next = ST_FINISH;
                end
                else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_FETCH;
                end
            end
            ST_NAME:
            begin
                // Wrap the name, then step to the next pattern for a tall lower half
                n_next     = n_mod + {9'd0, row_reg[3]};
                state_next = ST_PAT;
            end
            ST_PAT:
            begin
                x_cnt_next = '0;
                state_next = ST_DRAW;
            end
            ST_DRAW:
            begin
                x_cnt_next = x_cnt_reg + 1'b1;
                if (last_x) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (last_sprite) begin
                    state_next = ST_FINISH;
                end
                else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_FETCH;
                end
            end
            ST_READ:
            begin
                done_next  = 1'b1;
                pix_next   = line_rdata_reg;
                state_next = ST_IDLE;
            end
            ST_FINISH:
            begin
                done_next    = 1'b1;
                ovf_out_next = ovf_reg;
                col_out_next = coll_reg;
                state_next   = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            pend_reg     <= 1'b0;
            done_reg     <= 1'b0;
            idx_reg      <= '0;
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            coll_reg     <= 1'b0;
        end
        else begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            pend_reg     <= pend_next;
            done_reg     <= done_next;
            idx_reg      <= idx_next;
            count_reg    <= count_next;
            ovf_reg      <= ovf_next;
            coll_reg     <= coll_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        line_reg     <= line_next;
        xp_reg       <= xp_next;
        n_reg        <= n_next;
        row_reg      <= row_next;
        x_cnt_reg    <= x_cnt_next;
        pend_pos_reg <= pend_pos_next;
        pend_sp_reg  <= pend_sp_next;
        pix_reg      <= pix_next;
        ovf_out_reg  <= ovf_out_next;
        col_out_reg  <= col_out_next;
    end

    // Sprite attribute table
    always_ff @(posedge clk)
    begin
        if (spr_we) begin
            spr_mem[q_cmd.spr_idx[SIW-1:0]] <= {q_cmd.spr_y, q_cmd.spr_x, q_cmd.spr_name};
        end
        if (spr_re) begin
            spr_rdata_reg <= spr_mem[idx_reg];
        end
    end

    // Pattern store
    always_ff @(posedge clk)
    begin
        if (pat_we) begin
            pat_mem[pat_waddr] <= pat_wdata;
        end
        if (pat_re) begin
            pat_rdata_reg <= pat_mem[pat_raddr];
        end
    end

    // Line buffer
    always_ff @(posedge clk)
    begin
        if (line_we) begin
            line_mem[line_waddr] <= line_wdata;
        end
        if (line_re) begin
            line_rdata_reg <= line_mem[line_raddr];
        end
    end

endmodule

// ===== rtl/sprite_line_compositor_core.sv =====
// Top level of the sprite line compositor: front end, command queue, render engine.
// Depends on slc_pkg, slc_front, slc_queue and slc_engine.
//
//  channel   signals                                   transaction
//  command   start, busy, mode ... line                start high, busy low
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data  cfg_valid and cfg_ready high
//  result    done, pixel_out, overflow, collision      done high for one cycle
//
// Writes and no-op items give their result once popped, a read after the read state.
// A render fetches and evaluates each scanned sprite entry and takes each drawn sprite
// (width 8, or 16 when zoomed) through the name, pattern, draw and drain states, drawing
// one pixel per cycle. After reset a clearing pass over all PATTERN_COUNT*8 words zeroes
// the pattern store and line buffer; busy stays high meanwhile. Two commands can queue
// behind the engine; busy rises when the queue is full. Results cannot be stalled.
module sprite_line_compositor_core import slc_pkg::*; #(
    parameter int SPRITE_COUNT  = DEF_SPRITE_COUNT,
    parameter int PATTERN_COUNT = DEF_PATTERN_COUNT,
    parameter int MAX_PER_LINE  = DEF_MAX_PER_LINE
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  mode,
    input  logic [5:0]  sprite_index,
    input  logic [7:0]  sprite_y,
    input  logic [7:0]  sprite_x,
    input  logic [7:0]  sprite_name,
    input  logic [8:0]  pattern_index,
    input  logic [2:0]  pattern_row,
    input  logic [31:0] pattern_planes,
    input  logic [7:0]  pixel_x,
    input  logic [6:0]  pixel_value,
    input  logic [7:0]  line,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic        cfg_data,
    output logic        done,
    output logic [6:0]  pixel_out,
    output logic        overflow,
    output logic        collision
);

    cfg_t cfg_reg, cfg_next;
    cmd_t front_cmd, head_cmd;
    logic q_full, q_valid, q_pop, clearing, push;

    assign cfg_ready = 1'b1;
    assign busy      = clearing || q_full;
    assign push      = start && !busy;

    // Configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_TALL:  cfg_next.tall  = cfg_data;
                CFG_ZOOM:  cfg_next.zoom  = cfg_data;
                CFG_SHIFT: cfg_next.shift = cfg_data;
                CFG_HIGH:  cfg_next.high  = cfg_data;
                CFG_EXT:   cfg_next.ext   = cfg_data;
                default:   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg <= '0;
        end
        else begin
            cfg_reg <= cfg_next;
        end
    end

    slc_front #(
        .SPRITE_COUNT  (SPRITE_COUNT),
        .PATTERN_COUNT (PATTERN_COUNT)
    ) u_front (
        .mode           (mode),
        .sprite_index   (sprite_index),
        .sprite_y       (sprite_y),
        .sprite_x       (sprite_x),
        .sprite_name    (sprite_name),
        .pattern_index  (pattern_index),
        .pattern_row    (pattern_row),
        .pattern_planes (pattern_planes),
        .pixel_x        (pixel_x),
        .pixel_value    (pixel_value),
        .line           (line),
        .cmd            (front_cmd)
    );

    slc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (front_cmd),
        .pop      (q_pop),
        .full     (q_full),
        .valid    (q_valid),
        .head     (head_cmd)
    );

    slc_engine #(
        .SPRITE_COUNT  (SPRITE_COUNT),
        .PATTERN_COUNT (PATTERN_COUNT),
        .MAX_PER_LINE  (MAX_PER_LINE)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_cmd     (head_cmd),
        .q_pop     (q_pop),
        .clearing  (clearing),
        .done      (done),
        .pixel_out (pixel_out),
        .overflow  (overflow),
        .collision (collision)
    );

endmodule

// ===== sim/sprite_line_compositor_core_tb.sv =====
// Self-checking testbench for sprite_line_compositor_core: sprite, pattern and
// pixel writes, line renders and pixel reads, checked against an in-bench predictor.
// Depends on slc_pkg and the RTL top level only.
`timescale 1ns / 100ps

module sprite_line_compositor_core_tb;
    import slc_pkg::*;

    localparam int SPR_N       = 64;
    localparam int PAT_N       = 512;
    localparam int PER_LINE    = 8;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 150;
    localparam int TAIL_CYCLES = 400;
    localparam int CYCLE_LIMIT = 3000000;

    // Unused mode codes
    localparam logic [2:0] MODE_SPARE_LO = 3'd5;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [2:0]  mode;
        logic [5:0]  sprite_index;
        logic [7:0]  sprite_y;
        logic [7:0]  sprite_x;
        logic [7:0]  sprite_name;
        logic [8:0]  pattern_index;
        logic [2:0]  pattern_row;
        logic [31:0] pattern_planes;
        logic [7:0]  pixel_x;
        logic [6:0]  pixel_value;
        logic [7:0]  line;
    } line_cmd_t;

    typedef struct packed {
        logic [6:0] pixel;
        logic       ovf;
        logic       col;
    } line_result_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    line_cmd_t   cur;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic        cfg_data;
    logic        done;
    logic [6:0]  pixel_out;
    logic        overflow;
    logic        collision;

    sprite_line_compositor_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .mode           (cur.mode),
        .sprite_index   (cur.sprite_index),
        .sprite_y       (cur.sprite_y),
        .sprite_x       (cur.sprite_x),
        .sprite_name    (cur.sprite_name),
        .pattern_index  (cur.pattern_index),
        .pattern_row    (cur.pattern_row),
        .pattern_planes (cur.pattern_planes),
        .pixel_x        (cur.pixel_x),
        .pixel_value    (cur.pixel_value),
        .line           (cur.line),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .done           (done),
        .pixel_out      (pixel_out),
        .overflow       (overflow),
        .collision      (collision)
    );

    // Predictor state
    logic [7:0]  shadow_y    [SPR_N];
    logic [7:0]  shadow_x    [SPR_N];
    logic [7:0]  shadow_name [SPR_N];
    logic [31:0] shadow_pat  [PAT_N*8];
    logic [6:0]  shadow_line [256];
    cfg_t        shadow_cfg;

    // Stimulus-side view of the sprite table, used to keep renders on written entries
    bit          gen_written [SPR_N];
    logic [7:0]  gen_y       [SPR_N];
    bit          gen_ext;

    line_cmd_t    pending_cmds[$];
    line_result_t expected_results[$];
    int unsigned  issued;
    int unsigned  accepted;
    int unsigned  mismatches;
    int unsigned  cycles;
    bit           no_idle;
    int           gap;

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Bitplane bytes to packed nibbles, leftmost pixel in the low nibble
    function automatic logic [31:0] planes_to_nibbles(input logic [31:0] planes);
        logic [31:0] w;
        w = '0;
        for (int px = 0; px < 8; px++)
            for (int pl = 0; pl < 4; pl++)
                w[4*px + pl] = planes[8*pl + 7 - px];
        return w;
    endfunction

    // Sprite colour over buffer pixel
    function automatic logic [6:0] blend_pixel(input logic [6:0] bg, input logic [3:0] c);
        if ((bg & PIX_MARK) != '0)
            return bg;
        if (((bg & PIX_PRIO) != '0) && bg[3:0] != 4'd0)
            return bg | PIX_MARK;
        return {3'b000, c} | SPR_FILL;
    endfunction

    // Draw all sprites of one scanline into the shadow buffer
    function automatic void draw_scanline(input int ln, output logic ovf, output logic col);
        int   wid;
        int   hgt;
        int   hits;
        int   top;
        int   xp;
        int   row;
        int   xs;
        int   xe;
        int   px;
        int   pos;
        int   nm;
        logic [31:0] word;
        logic [3:0]  c;
        logic [6:0]  seen;
        wid  = shadow_cfg.zoom ? 16 : 8;
        hgt  = (shadow_cfg.tall ? 16 : 8) * (shadow_cfg.zoom ? 2 : 1);
        hits = 0;
        seen = '0;
        ovf  = 1'b0;
        for (int i = 0; i < SPR_N; i++) begin
            top = int'(shadow_y[i]);
            if (!shadow_cfg.ext && top == 208)
                break;
            top++;
            if (top > 240)
                top -= 256;
            if (ln >= top && ln < top + hgt) begin
                hits++;
                if (hits == PER_LINE + 1) begin
                    ovf = 1'b1;
                    break;
                end
                xp = int'(shadow_x[i]);
                nm = int'(shadow_name[i]);
                if (shadow_cfg.shift)
                    xp -= 8;
                if (shadow_cfg.high)
                    nm |= 256;
                if (shadow_cfg.tall)
                    nm &= 'h1FE;
                xs = (xp < 0) ? -xp : 0;
                xe = (xp + wid > 256) ? 256 - xp : wid;
                row = ln - top;
                if (shadow_cfg.zoom)
                    row = row >> 1;
                nm = (nm + (row >> 3)) % PAT_N;
                word = shadow_pat[(nm << 3) | (row & 7)];
                for (int x = xs; x < xe; x++) begin
                    px = shadow_cfg.zoom ? (x >> 1) : x;
                    c = word[4*(px & 7) +: 4];
                    if (c != 4'd0) begin
                        pos = (xp + x) & 255;
                        seen |= shadow_line[pos];
                        shadow_line[pos] = blend_pixel(shadow_line[pos], c);
                    end
                end
            end
        end
        col = (seen & PIX_MARK) != '0;
    endfunction

    // Apply one accepted command and return its result
    function automatic line_result_t apply_command(input line_cmd_t cmd);
        line_result_t r;
        r = '0;
        case (cmd.mode)
            MODE_SPRITE: begin
                shadow_y[cmd.sprite_index]    = cmd.sprite_y;
                shadow_x[cmd.sprite_index]    = cmd.sprite_x;
                shadow_name[cmd.sprite_index] = cmd.sprite_name;
            end
            MODE_PATTERN:
                shadow_pat[{cmd.pattern_index, cmd.pattern_row}] =
                    planes_to_nibbles(cmd.pattern_planes);
            MODE_PIXEL:
                shadow_line[cmd.pixel_x] = cmd.pixel_value;
            MODE_RENDER:
                draw_scanline(int'(cmd.line), r.ovf, r.col);
            MODE_READ:
                r.pixel = shadow_line[cmd.pixel_x];
            default: ;
        endcase
        return r;
    endfunction

    // Command driver: changes on the falling edge, holds until accepted
    always @(negedge clk) begin
        if (!rst_n) begin
            start <= 1'b0;
        end
        else if (issued != accepted) begin
            start <= 1'b1;
        end
        else if (gap > 0) begin
            gap   <= gap - 1;
            start <= 1'b0;
        end
        else if (pending_cmds.size() != 0) begin
            cur    <= pending_cmds.pop_front();
            start  <= 1'b1;
            issued <= issued + 1;
            if (no_idle)
                gap <= 0;
            else
                case ($urandom_range(99) / 10)
                    0, 1: gap <= $urandom_range(3, 1);
                    2:    gap <= ($urandom_range(9) == 0) ? $urandom_range(40, 10) : 0;
                    default: gap <= 0;
                endcase
        end
        else begin
            start <= 1'b0;
        end
    end

    // Acceptance and result check on the rising edge
    always @(posedge clk) begin
        line_result_t want;
        if (rst_n) begin
            if (done) begin
                if (expected_results.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("%0t: result with no transaction pending: %h %b %b",
                                 $realtime, pixel_out, overflow, collision);
                end
                else begin
                    want = expected_results.pop_front();
                    if (want.pixel !== pixel_out || want.ovf !== overflow ||
                        want.col !== collision) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("%0t: exp pixel %h ovf %b col %b, got %h %b %b",
                                     $realtime, want.pixel, want.ovf, want.col,
                                     pixel_out, overflow, collision);
                    end
                end
            end
            if (start && !busy) begin
                expected_results.push_back(apply_command(cur));
                accepted <= accepted + 1;
            end
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Register write, issued with no commands outstanding; the task itself does not wait for idle
    task automatic write_reg(input logic [2:0] idx, input logic val);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_TALL:  shadow_cfg.tall  = val;
            CFG_ZOOM:  shadow_cfg.zoom  = val;
            CFG_SHIFT: shadow_cfg.shift = val;
            CFG_HIGH:  shadow_cfg.high  = val;
            CFG_EXT:   shadow_cfg.ext   = val;
            default: ;
        endcase
        if (idx == CFG_EXT)
            gen_ext = val;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_cmds.size() != 0 || issued != accepted || expected_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    function automatic line_cmd_t blank_cmd(input logic [2:0] m);
        line_cmd_t   c;
        logic [127:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom};
        c = raw[$bits(line_cmd_t)-1:0];
        c.mode = m;
        return c;
    endfunction

    function automatic void push_sprite(input int idx, input int y, input int x, input int nm);
        line_cmd_t c;
        c = blank_cmd(MODE_SPRITE);
        c.sprite_index = 6'(idx);
        c.sprite_y = 8'(y);
        c.sprite_x = 8'(x);
        c.sprite_name = 8'(nm);
        gen_written[idx] = 1'b1;
        gen_y[idx] = 8'(y);
        pending_cmds.push_back(c);
    endfunction

    function automatic void push_pattern(input int idx, input int row, input logic [31:0] pl);
        line_cmd_t c;
        c = blank_cmd(MODE_PATTERN);
        c.pattern_index = 9'(idx);
        c.pattern_row = 3'(row);
        c.pattern_planes = pl;
        pending_cmds.push_back(c);
    endfunction

    function automatic void push_pixel(input logic [2:0] m, input int x, input int v);
        line_cmd_t c;
        c = blank_cmd(m);
        c.pixel_x = 8'(x);
        c.pixel_value = 7'(v);
        pending_cmds.push_back(c);
    endfunction

    function automatic int rand_y();
        case ($urandom_range(9))
            0:       return 208;
            1, 2, 3: return $urandom_range(255, 230);
            4:       return $urandom_range(255);
            default: return $urandom_range(40);
        endcase
    endfunction

    function automatic int rand_x();
        case ($urandom_range(9))
            0, 1, 2: return $urandom_range(8);
            3, 4, 5: return $urandom_range(255, 240);
            default: return $urandom_range(255);
        endcase
    endfunction

    function automatic int rand_name_or_pat(input int top);
        case ($urandom_range(9))
            0, 1, 2, 3: return $urandom_range(8);
            4, 5:       return $urandom_range(263, 248) % (top + 1);
            6, 7:       return $urandom_range(top, top - 7);
            default:    return $urandom_range(top);
        endcase
    endfunction

    // Render only once every entry up to the end marker has been written
    function automatic void push_render(input int ln);
        line_cmd_t c;
        for (int i = 0; i < SPR_N; i++) begin
            if (!gen_ext && gen_written[i] && gen_y[i] == 8'd208)
                break;
            if (!gen_written[i])
                push_sprite(i, rand_y(), rand_x(), rand_name_or_pat(255));
        end
        c = blank_cmd(MODE_RENDER);
        c.line = 8'(ln);
        pending_cmds.push_back(c);
    endfunction

    function automatic void push_random_item();
        line_cmd_t c;
        int k;
        k = $urandom_range(99);
        if (k < 25)
            push_sprite($urandom_range(SPR_N - 1), rand_y(), rand_x(), rand_name_or_pat(255));
        else if (k < 45)
            push_pattern(rand_name_or_pat(PAT_N - 1), $urandom_range(7), $urandom);
        else if (k < 58)
            push_pixel(MODE_PIXEL, $urandom_range(255), $urandom_range(127));
        else if (k < 75)
            case ($urandom_range(4))
                0, 1:    push_render($urandom_range(40));
                2:       push_render($urandom_range(255, 230));
                default: push_render($urandom_range(255));
            endcase
        else if (k < 95)
            push_pixel(MODE_READ, rand_x(), 0);
        else begin
            c = blank_cmd(3'($urandom_range(MODE_SPARE_HI, MODE_SPARE_LO)));
            pending_cmds.push_back(c);
        end
    endfunction

    initial begin
        logic [4:0] bits;
        rst_n      = 1'b0;
        start      = 1'b0;
        cur        = '0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = 1'b0;
        issued     = 0;
        accepted   = 0;
        mismatches = 0;
        cycles     = 0;
        gap        = 0;
        no_idle    = 1'b0;
        gen_ext    = 1'b0;
        shadow_cfg = '0;
        for (int i = 0; i < PAT_N*8; i++) shadow_pat[i] = '0;
        for (int i = 0; i < 256; i++) shadow_line[i] = '0;
        for (int i = 0; i < SPR_N; i++) begin
            shadow_y[i] = '0;
            shadow_x[i] = '0;
            shadow_name[i] = '0;
            gen_written[i] = 1'b0;
            gen_y[i] = '0;
        end
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       bits = 5'b00000;
                1:       bits = 5'b11111;
                2:       bits = 5'b10001;
                3:       bits = 5'b01110;
                default: bits = 5'($urandom_range(31));
            endcase
            write_reg(CFG_TALL,  bits[4]);
            write_reg(CFG_ZOOM,  bits[3]);
            write_reg(CFG_SHIFT, bits[2]);
            write_reg(CFG_HIGH,  bits[1]);
            write_reg(CFG_EXT,   bits[0]);
            no_idle = (p % 3 == 2);

            if (p == 0) begin
                // Directed: extreme planes, priority and mark pixels, nine sprites on a line,
                // right edge clip, end marker, reads and an unused mode
                push_pattern(0, 0, 32'hFFFF_FFFF);
                push_pattern(PAT_N - 1, 7, 32'hA5C3_0F81);
                push_pattern(1, 1, 32'h0000_0000);
                push_pixel(MODE_PIXEL, 0, PIX_MARK | 7'd5);
                push_pixel(MODE_PIXEL, 255, PIX_PRIO | 7'd3);
                push_pixel(MODE_PIXEL, 20, PIX_PRIO);
                push_pixel(MODE_PIXEL, 100, 127);
                for (int i = 0; i < 9; i++)
                    push_sprite(i, 9, (i == 1) ? 252 : i * 20, 0);
                push_sprite(9, 208, 0, 0);
                push_render(10);
                push_pixel(MODE_READ, 0, 0);
                push_pixel(MODE_READ, 255, 0);
                push_pixel(MODE_READ, 20, 0);
                push_pixel(MODE_READ, 40, 0);
                pending_cmds.push_back(blank_cmd(MODE_SPARE_HI));
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
                push_random_item();
            wait_idle();
        end

        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/slc_pkg.sv
rtl/slc_front.sv
rtl/slc_queue.sv
rtl/slc_engine.sv
rtl/sprite_line_compositor_core.sv
sim/sprite_line_compositor_core_tb.sv
